### hdl/oksm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oksm_pkg
// Shared types and constants of the ordered key sequence matcher.
// ----------------------------------------------------------------------------
package oksm_pkg;

  localparam int POS_W        = 4;   // position, held count, member count
  localparam int IDS_W        = 64;  // packed member id register
  localparam int KEY_W        = 8;   // input id field
  localparam int SLOT_BITS    = 3;   // log2 of id slots in the packed register
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_IDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEDANTIC     = 2'd2;

  typedef enum logic [2:0] {
    MS_PROGRESS  = 3'd0,
    MS_INVALID   = 3'd1,
    MS_MATCHES   = 3'd2,
    MS_FINALIZED = 3'd3,
    MS_RELEASING = 3'd4
  } match_state_t;

  // one key event as taken from the input channel
  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] input_id;
    logic             pressed;
    logic             consume_only;
  } event_t;

  // one result beat, consumed in the lowest bit
  typedef struct packed {
    logic [POS_W-1:0] progress;
    match_state_t     match_state;
    logic             consumed;
  } out_beat_t;

endpackage : oksm_pkg
`default_nettype wire

### hdl/oksm_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oksm_cmp
// Shared id compare unit: selects one member id and compares it to the key.
// ----------------------------------------------------------------------------
module oksm_cmp
  import oksm_pkg::*;
#(
  parameter int MAX_MEMBERS = 8,
  parameter int ID_BITS     = 8
) (
  input  wire logic [IDS_W-1:0]               member_ids,
  input  wire logic [$clog2(MAX_MEMBERS)-1:0] idx,
  input  wire logic [KEY_W-1:0]               input_id,
  output logic                                id_eq
);

  logic [SLOT_BITS+2:0] base;

  // each member occupies one byte; only the low ID_BITS bits count
  assign base  = {SLOT_BITS'(idx), 3'b000};
  assign id_eq = (member_ids[base +: ID_BITS] == input_id[ID_BITS-1:0]);

endmodule : oksm_cmp
`default_nettype wire

### hdl/oksm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oksm_seq
// Sequencer and match state: drives the compare unit and applies each event.
// ----------------------------------------------------------------------------
module oksm_seq
  import oksm_pkg::*;
#(
  parameter int MAX_MEMBERS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           ev_valid,
  output logic                                ev_ready,
  input  wire event_t                         ev,
  input  wire logic [POS_W-1:0]               count,
  input  wire logic                           pedantic,
  output logic [$clog2(MAX_MEMBERS)-1:0]      idx,
  output logic [KEY_W-1:0]                    cmp_id,
  input  wire logic                           id_eq,
  input  wire logic                           out_free,
  output logic                                res_valid,
  output out_beat_t                           res
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MEMBERS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRESS = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } seq_state_t;

  seq_state_t             st_r, st_nxt;
  event_t                 ev_r;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       hcnt_r, hcnt_nxt;
  logic [MAX_MEMBERS-1:0] held_r, held_nxt;
  logic                   allp_r, allp_nxt;
  logic                   hit_r, hit_nxt;
  match_state_t           mst_r, mst_nxt;

  logic [POS_W-1:0]       limit;
  logic [POS_W-1:0]       scan_pos;
  logic                   in_range;
  logic                   scan_last;
  logic                   pos_ok;

  assign ev_ready  = (st_r == S_IDLE);
  assign cmp_id    = ev_r.input_id;
  assign idx       = (st_r == S_SCAN) ? scan_r : IDX_W'(pos_r);
  assign limit     = (pos_r > MAX_POS) ? MAX_POS : pos_r;
  assign scan_pos  = POS_W'(scan_r);
  assign in_range  = (scan_pos < limit);
  assign scan_last = ((scan_pos + POS_W'(1)) == limit);
  assign pos_ok    = (pos_r < count);

  always_comb begin
    st_nxt    = st_r;
    scan_nxt  = scan_r;
    pos_nxt   = pos_r;
    hcnt_nxt  = hcnt_r;
    held_nxt  = held_r;
    allp_nxt  = allp_r;
    hit_nxt   = hit_r;
    mst_nxt   = mst_r;
    res_valid = 1'b0;
    res       = '{progress: pos_r, match_state: mst_r, consumed: hit_r};
    unique case (st_r)
      S_IDLE: begin
        if (ev_valid) begin
          hit_nxt  = 1'b0;
          scan_nxt = '0;
          st_nxt   = (!ev.req_type && !ev.pressed) ? S_SCAN : S_PRESS;
        end
      end
      S_PRESS: begin
        st_nxt = S_FIN;
        if (ev_r.req_type) begin
          pos_nxt  = '0;
          hcnt_nxt = '0;
          held_nxt = '0;
          allp_nxt = 1'b0;
          mst_nxt  = MS_PROGRESS;
        end else if (pos_ok && id_eq) begin
          held_nxt[IDX_W'(pos_r)] = 1'b1;
          pos_nxt  = pos_r + POS_W'(1);
          hcnt_nxt = hcnt_r + POS_W'(1);
          hit_nxt  = 1'b1;
        end else if (!ev_r.consume_only) begin
          mst_nxt = MS_INVALID;
        end
      end
      S_SCAN: begin
        // one member per cycle, first held match in list order wins
        if (!in_range) begin
          st_nxt = S_FIN;
        end else if (id_eq && held_r[scan_r]) begin
          held_nxt[scan_r] = 1'b0;
          hcnt_nxt = hcnt_r - POS_W'(1);
          hit_nxt  = 1'b1;
          st_nxt   = S_FIN;
        end else if (scan_last) begin
          st_nxt = S_FIN;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        // hold until the output register has room, then settle the state
        if (out_free) begin
          if (hit_r) begin
            mst_nxt = MS_PROGRESS;
            if (!pos_ok && !allp_r) begin
              allp_nxt = 1'b1;
              if (!pedantic) begin
                mst_nxt = MS_MATCHES;
              end
            end else if (hcnt_r == '0) begin
              if (allp_r) begin
                mst_nxt = pedantic ? MS_MATCHES : MS_FINALIZED;
              end
            end else if (allp_r) begin
              mst_nxt = MS_RELEASING;
            end
          end
          res_valid = 1'b1;
          res       = '{progress: pos_r, match_state: mst_nxt, consumed: hit_r};
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      scan_r <= '0;
      pos_r  <= '0;
      hcnt_r <= '0;
      held_r <= '0;
      allp_r <= 1'b0;
      hit_r  <= 1'b0;
      mst_r  <= MS_PROGRESS;
    end else begin
      st_r   <= st_nxt;
      scan_r <= scan_nxt;
      pos_r  <= pos_nxt;
      hcnt_r <= hcnt_nxt;
      held_r <= held_nxt;
      allp_r <= allp_nxt;
      hit_r  <= hit_nxt;
      mst_r  <= mst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      ev_r <= ev;
    end
  end

endmodule : oksm_seq
`default_nettype wire

### hdl/ordered_key_sequence_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_key_sequence_matcher
// Checks key press, release and restart beats against a configured ordered id list.
// ----------------------------------------------------------------------------
// Each input beat gives exactly one result beat. A restart or a press passes
// through capture, one compare and settle; a release passes through capture,
// a scan in which the shared id comparator examines the members one at a
// time, with at least one scan step even when nothing has been pressed, and
// settle. The input is ready again the cycle after a result is loaded; a
// result that waits in the output register holds the block in its final step
// only until that register frees.
module ordered_key_sequence_matcher
  import oksm_pkg::*;
#(
  parameter int MAX_MEMBERS = 8,
  parameter int ID_BITS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // input_id, pressed, consume_only, zero pad
  input  wire logic                  in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // consumed, match_state, progress
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [IDS_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MEMBERS);

  logic [IDS_W-1:0] ids_r;
  logic [POS_W-1:0] mcount_r;
  logic             ped_r;
  logic [POS_W-1:0] count_eff;

  event_t           ev;
  logic [IDX_W-1:0] idx;
  logic [KEY_W-1:0] cmp_id;
  logic             id_eq;
  logic             out_free;
  logic             res_valid;
  out_beat_t        res;
  logic             out_valid_r;
  out_beat_t        out_beat_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r    <= '0;
      mcount_r <= POS_W'(1);
      ped_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MEMBER_IDS:   ids_r    <= cfg_data;
        REG_MEMBER_COUNT: mcount_r <= cfg_data[POS_W-1:0];
        REG_PEDANTIC:     ped_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the list size saturates
  assign count_eff = (mcount_r == '0)     ? POS_W'(1) :
                     (mcount_r > MAX_POS) ? MAX_POS   : mcount_r;

  assign ev = '{req_type:     in_tuser,
                input_id:     in_tdata[KEY_W-1:0],
                pressed:      in_tdata[KEY_W],
                consume_only: in_tdata[KEY_W+1]};

  oksm_seq #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (in_tvalid),
    .ev_ready  (in_tready),
    .ev        (ev),
    .count     (count_eff),
    .pedantic  (ped_r),
    .idx       (idx),
    .cmp_id    (cmp_id),
    .id_eq     (id_eq),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  oksm_cmp #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .ID_BITS     (ID_BITS)
  ) u_cmp (
    .member_ids (ids_r),
    .idx        (idx),
    .input_id   (cmp_id),
    .id_eq      (id_eq)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_beat_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready right after an accepted beat");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_tvalid)
    else $error("settled result not held in output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_tready))
    else $error("result overwrote a beat not yet taken");

  a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.progress <= MAX_POS))
    else $error("progress beyond list size");
`endif

endmodule : ordered_key_sequence_matcher
`default_nettype wire

### sim/tb_ordered_key_sequence_matcher.sv
// ----------------------------------------------------------------------------
// tb_ordered_key_sequence_matcher
// Self-checking bench for the ordered key sequence matcher.
// ----------------------------------------------------------------------------
// Key events are queued by the stimulus block and sent by a bursty driver.
// Every accepted beat runs through a local copy of the matcher state, which
// queues the expected result. The monitor checks each result beat field by
// field while the receiver stalls on a changing pattern. Register writes
// happen only between phases, once the block has gone quiet.
module tb_ordered_key_sequence_matcher;
  import oksm_pkg::*;

  localparam int MAX_MEMBERS   = 8;
  localparam int ID_BITS       = 8;
  localparam int SETTLE_CYCLES = MAX_MEMBERS + 4;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_EVENTS  = 106;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << ID_BITS) - 1);

  typedef struct {
    event_t ev;
    bit     drain_first;   // wait until every result is back before sending
  } pending_event_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_QUARTER,
    STALL_LONG
  } stall_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [IDS_W-1:0]     cfg_data   = '0;

  // register shadow
  logic [IDS_W-1:0] cfg_ids      = '0;
  logic [POS_W-1:0] cfg_count    = POS_W'(1);
  logic             cfg_pedantic = 1'b0;

  // sequence state shadow
  logic [POS_W-1:0]       seq_pos     = '0;
  logic [MAX_MEMBERS-1:0] held_mask   = '0;
  logic [POS_W-1:0]       held_total  = '0;
  logic                   all_down    = 1'b0;
  match_state_t           seq_state   = MS_PROGRESS;

  pending_event_t pending_events[$];
  out_beat_t      expected_beats[$];
  event_t         sent_event;
  bit             hold_next       = 1'b0;
  int             queued_events   = 0;
  int             mismatch_count  = 0;
  int             burst_left      = 1;
  int             gap_left        = 0;
  int             quiet_cycles    = 0;
  int             stall_hold      = 0;
  logic [9:0]     stall_tick      = '0;

  ordered_key_sequence_matcher #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .ID_BITS     (ID_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [KEY_W-1:0] member_key(input int slot);
    return cfg_ids[(slot & 7) * 8 +: 8] & KEY_MASK;
  endfunction

  function automatic int active_members();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_MEMBERS) return MAX_MEMBERS;
    return int'(cfg_count);
  endfunction

  // Advance the sequence shadow by one accepted event and queue its result.
  task automatic apply_key_event(input event_t ev);
    logic [KEY_W-1:0] key;
    int               limit;
    logic             hit;
    out_beat_t        beat;
    key   = ev.input_id & KEY_MASK;
    limit = active_members();
    hit   = 1'b0;
    if (ev.req_type) begin
      seq_pos    = '0;
      held_mask  = '0;
      held_total = '0;
      all_down   = 1'b0;
      seq_state  = MS_PROGRESS;
    end else if (ev.pressed) begin
      if (int'(seq_pos) < limit && member_key(int'(seq_pos)) == key) begin
        held_mask[seq_pos[2:0]] = 1'b1;
        seq_pos    = seq_pos + POS_W'(1);
        held_total = held_total + POS_W'(1);
        hit        = 1'b1;
      end else if (!ev.consume_only) begin
        seq_state = MS_INVALID;
      end
    end else begin
      // release the first pressed member still held with this id
      for (int i = 0; i < int'(seq_pos) && i < MAX_MEMBERS; i++) begin
        if (!hit && member_key(i) == key && held_mask[i]) begin
          held_mask[i] = 1'b0;
          held_total   = held_total - POS_W'(1);
          hit          = 1'b1;
        end
      end
    end
    if (hit) begin
      seq_state = MS_PROGRESS;
      if (int'(seq_pos) >= limit && !all_down) begin
        all_down = 1'b1;
        if (!cfg_pedantic) seq_state = MS_MATCHES;
      end else if (held_total == 0) begin
        if (all_down) seq_state = cfg_pedantic ? MS_MATCHES : MS_FINALIZED;
      end else if (all_down) begin
        seq_state = MS_RELEASING;
      end
    end
    beat.consumed    = hit;
    beat.match_state = seq_state;
    beat.progress    = seq_pos;
    expected_beats.push_back(beat);
  endtask

  always @(posedge clk) begin : drive_in
    pending_event_t nxt;
    logic           fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) apply_key_event(sent_event);
      if (in_tvalid && !fire) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_events.size() > 0 &&
                   (!pending_events[0].drain_first || expected_beats.size() == 0)) begin
        nxt = pending_events.pop_front();
        in_tvalid  <= 1'b1;
        in_tuser   <= nxt.ev.req_type;
        in_tdata   <= {{(IN_DATA_W-KEY_W-2){1'b0}}, nxt.ev.consume_only,
                       nxt.ev.pressed, nxt.ev.input_id};
        sent_event <= nxt.ev;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : stall_out
    stall_mode_t mode;
    mode       = stall_mode_t'(stall_tick[9:8]);
    stall_tick <= stall_tick + 10'd1;
    case (mode)
      STALL_NONE:    out_tready <= 1'b1;
      STALL_COIN:    out_tready <= 1'($urandom_range(0, 1));
      STALL_QUARTER: out_tready <= (stall_tick[1:0] == 2'd0);
      default: begin
        if (stall_hold > 0) begin
          out_tready <= 1'b0;
          stall_hold <= stall_hold - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_hold <= $urandom_range(1, 15);
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_out
    out_beat_t got;
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_beat_t'(out_tdata);
      if (expected_beats.size() == 0) begin
        $error("result beat %h with nothing expected", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got.consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
          mismatch_count++;
        end
        if (got.match_state !== want.match_state) begin
          $error("match_state: expected %0d, got %0d", want.match_state, got.match_state);
          mismatch_count++;
        end
        if (got.progress !== want.progress) begin
          $error("progress: expected %0d, got %0d", want.progress, got.progress);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_event(input logic req, input logic [KEY_W-1:0] id,
                             input logic pr, input logic co);
    pending_event_t item;
    item.ev.req_type     = req;
    item.ev.input_id     = id;
    item.ev.pressed      = pr;
    item.ev.consume_only = co;
    item.drain_first     = hold_next;
    hold_next            = 1'b0;
    pending_events.push_back(item);
    queued_events++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MEMBER_IDS:   cfg_ids      = value;
      REG_MEMBER_COUNT: cfg_count    = value[POS_W-1:0];
      REG_PEDANTIC:     cfg_pedantic = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_tvalid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    if ($urandom_range(0, 1) == 0) return member_key($urandom_range(0, MAX_MEMBERS - 1));
    return KEY_W'($urandom_range(0, 255));
  endfunction

  // Mostly an ordered press run with random releases mixed in, then releases of
  // the members in shuffled order, each one skipped with a chance of one in eight.
  task automatic queue_sequence();
    int n;
    int t;
    int k;
    int order[MAX_MEMBERS];
    n = active_members();
    if ($urandom_range(0, 39) == 0) hold_next = 1'b1;
    if ($urandom_range(0, 7) != 0) queue_event(1'b1, any_key(), 1'($urandom), 1'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) queue_event(1'b0, any_key(), 1'b1, 1'b1);
      if (i > 0 && $urandom_range(0, 5) == 0)
        queue_event(1'b0, member_key($urandom_range(0, i - 1)), 1'b0, 1'($urandom));
      queue_event(1'b0, member_key(i), 1'b1, 1'($urandom_range(0, 3) == 0));
    end
    if ($urandom_range(0, 3) == 0) queue_event(1'b0, any_key(), 1'b1, 1'($urandom));
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 7) != 0)
        queue_event(1'b0, member_key(order[i]), 1'b0, 1'($urandom));
  endtask

  task automatic queue_noise();
    int k;
    k = $urandom_range(1, 8);
    repeat (k)
      queue_event(1'($urandom_range(0, 9) == 0), any_key(), 1'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    logic [IDS_W-1:0] ids;
    logic [7:0]       pool[3];
    logic [POS_W-1:0] count;
    int               target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one member with id zero
    queue_event(1'b0, 8'h00, 1'b1, 1'b0);   // completes the list
    queue_event(1'b0, 8'h00, 1'b1, 1'b0);   // press past the end
    queue_event(1'b0, 8'h00, 1'b0, 1'b0);   // last release finalizes
    queue_event(1'b0, 8'h00, 1'b0, 1'b0);   // nothing held: ignored
    queue_event(1'b1, 8'h5A, 1'b1, 1'b1);
    queue_event(1'b0, 8'hFF, 1'b1, 1'b1);   // wrong press, consume only
    queue_event(1'b0, 8'hFF, 1'b1, 1'b0);   // wrong press invalidates
    hold_next = 1'b1;
    queue_event(1'b1, 8'h00, 1'b0, 1'b0);
    wait_drained();

    // full list with a repeated id, pedantic
    write_reg(REG_MEMBER_IDS, 64'hFFA5_5A0F_F080_0180);
    write_reg(REG_MEMBER_COUNT, 64'd8);
    write_reg(REG_PEDANTIC, 64'd1);
    for (int i = 0; i < MAX_MEMBERS; i++) queue_event(1'b0, member_key(i), 1'b1, 1'b0);
    queue_event(1'b0, 8'h80, 1'b0, 1'b0);   // first holder of the repeated id
    queue_event(1'b0, 8'h80, 1'b0, 1'b0);   // then the second one
    queue_event(1'b0, 8'h01, 1'b0, 1'b0);
    queue_event(1'b0, 8'hF0, 1'b0, 1'b0);
    queue_event(1'b0, 8'h0F, 1'b0, 1'b0);
    queue_event(1'b0, 8'h5A, 1'b0, 1'b0);
    queue_event(1'b0, 8'hA5, 1'b0, 1'b0);
    queue_event(1'b0, 8'hFF, 1'b0, 1'b0);
    queue_event(1'b0, 8'h80, 1'b1, 1'b0);
    wait_drained();

    // state is kept across phases, so a smaller count can land mid-sequence
    for (int p = 0; p < 16; p++) begin
      case ($urandom_range(0, 5))
        0: ids = '0;
        1: ids = '1;
        2, 3: ids = {$urandom, $urandom};
        default: begin
          foreach (pool[j]) pool[j] = 8'($urandom);
          for (int j = 0; j < 8; j++) ids[j*8 +: 8] = pool[$urandom_range(0, 2)];
        end
      endcase
      if (p == 0) count = '0;
      else if (p == 1) count = '1;
      else if ($urandom_range(0, 4) == 0) count = POS_W'($urandom_range(0, 15));
      else count = POS_W'($urandom_range(1, MAX_MEMBERS));
      if (p < 2 || $urandom_range(0, 2) != 0) write_reg(REG_MEMBER_IDS, ids);
      if (p < 2 || $urandom_range(0, 2) != 0)
        write_reg(REG_MEMBER_COUNT, {$urandom, 28'($urandom), count});
      if (p < 2 || $urandom_range(0, 2) != 0)
        write_reg(REG_PEDANTIC, {$urandom, 31'($urandom), 1'(p == 1 || $urandom_range(0, 1))});
      target = queued_events + PHASE_EVENTS;
      while (queued_events < target) begin
        if ($urandom_range(0, 9) < 7) queue_sequence();
        else queue_noise();
      end
      wait_drained();
    end

    if (expected_beats.size() != 0) begin
      $error("%0d results never arrived", expected_beats.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
